[rtl/mf3_pkg.sv]
package mf3_pkg;

   localparam int PIXEL_BITS    = 8;
   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = 11;
   localparam int OUT_ROW_BITS  = 10;
   localparam int DIM_BITS      = 11;
   localparam int COUNT_BITS    = 21;
   localparam int WINDOW_TAPS   = 9;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(1024);
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(1024);
   localparam logic [PIXEL_BITS-1:0] DARK_RESET   = PIXEL_BITS'(50);
   localparam logic [PIXEL_BITS-1:0] BRIGHT_RESET = PIXEL_BITS'(200);

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef pixel_type [WINDOW_TAPS-1:0] window_type;

   typedef enum logic [1:0] {
      CLASS_DARK   = 2'd0,
      CLASS_BRIGHT = 2'd1,
      CLASS_NORMAL = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_DARK_LIMIT   = 2'd2,
      CSR_BRIGHT_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      pixel_type upper;
      pixel_type lower;
   } line_pair_type;

   typedef struct packed {
      logic                rd_en;
      logic [COL_BITS-1:0] rd_addr;
      logic                wr_en;
      logic [COL_BITS-1:0] wr_addr;
      line_pair_type       wr_data;
   } lsr_req_type;

   typedef struct packed {
      logic                    produce;
      logic                    done;
      logic [COL_BITS-1:0]     cc;
      logic [OUT_ROW_BITS-1:0] cr;
      logic                    top_ok;
      logic                    bot_ok;
      logic                    left_ok;
      logic                    right_ok;
   } pos_meta_type;

   typedef struct packed {
      class_type               cls;
      logic [COL_BITS-1:0]     cc;
      logic [OUT_ROW_BITS-1:0] cr;
      logic                    done;
      logic [COUNT_BITS-1:0]   dark;
      logic [COUNT_BITS-1:0]   bright;
      logic [COUNT_BITS-1:0]   normal;
   } rsp_meta_type;

endpackage

[rtl/mf3_line_store.sv]
module mf3_line_store
   import mf3_pkg::*;
(
   input  logic          clock,
   input  lsr_req_type   req,
   output line_pair_type rd_data
);

   // upper and lower line share one entry per column
   line_pair_type mem [MAX_WIDTH];
   line_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mf3_median.sv]
module mf3_median
   import mf3_pkg::*;
(
   input  logic       clock,
   input  logic       ld_box,
   input  logic       ld_rows,
   input  logic       ld_med,
   input  window_type box_in,
   output pixel_type  median
);

   function automatic pixel_type min2(input pixel_type a, input pixel_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pixel_type max2(input pixel_type a, input pixel_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic pixel_type med3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   window_type box_ff;
   window_type rows_ff;
   window_type rows_in;
   pixel_type  med_ff;
   pixel_type  med_in;
   pixel_type  lo_max;
   pixel_type  mid_med;
   pixel_type  hi_min;

   // each row sorted into low, middle, high
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rows_in[r*3]   = min2(min2(box_ff[r*3], box_ff[r*3+1]), box_ff[r*3+2]);
         rows_in[r*3+1] = med3(box_ff[r*3], box_ff[r*3+1], box_ff[r*3+2]);
         rows_in[r*3+2] = max2(max2(box_ff[r*3], box_ff[r*3+1]), box_ff[r*3+2]);
      end
   end

   // median of nine from the sorted rows
   always_comb begin
      lo_max  = max2(max2(rows_ff[0], rows_ff[3]), rows_ff[6]);
      mid_med = med3(rows_ff[1], rows_ff[4], rows_ff[7]);
      hi_min  = min2(min2(rows_ff[2], rows_ff[5]), rows_ff[8]);
      med_in  = med3(lo_max, mid_med, hi_min);
   end

   always_ff @(posedge clock) begin
      if (ld_box) begin
         box_ff <= box_in;
      end
      if (ld_rows) begin
         rows_ff <= rows_in;
      end
      if (ld_med) begin
         med_ff <= med_in;
      end
   end

   assign median = med_ff;

endmodule

[rtl/median_filter_3x3_with_pixel_classes_top.sv]
// 3x3 median filter with dark / bright / normal pixel classes.
// req channel: one pixel per transfer in raster order (req_pixel, req_is_pad);
// after each frame the source sends frame_width+1 pad transfers to flush it.
// rsp channel: one transfer per frame pixel, carrying the median of its
// zero-padded 3x3 window, the class of the centre pixel, its column and row,
// the running class totals and frame_done on the frame's last pixel.
// the result for a pixel follows the transfer frame_width+1 positions later,
// and passes stages 1, 2 and 3 before rsp_valid rises. throughput is one
// transfer per cycle while unstalled; the line store does one read and one
// write per cycle, and the window and median network are fully pipelined.
// configuration goes through the apb port while the block is idle (the user's
// duty; unenforced); a write to frame_width or frame_height restarts the frame
// and clears the totals. reset clears the pipeline, position counters, totals
// and window taps and loads the register defaults; line store contents are not
// cleared, since every tap outside the frame is masked to zero.
// when rsp_ready is low the result holds in the output register and the
// pipeline keeps absorbing transfers until it is full, then drops req_ready.
module median_filter_3x3_with_pixel_classes_top
   import mf3_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [PIXEL_BITS-1:0]    req_pixel,
   input  logic                     req_is_pad,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PIXEL_BITS-1:0]    rsp_median,
   output logic [1:0]               rsp_center_class,
   output logic [COL_BITS-1:0]      rsp_center_column,
   output logic [OUT_ROW_BITS-1:0]  rsp_center_row,
   output logic                     rsp_frame_done,
   output logic [COUNT_BITS-1:0]    rsp_dark_count,
   output logic [COUNT_BITS-1:0]    rsp_bright_count,
   output logic [COUNT_BITS-1:0]    rsp_normal_count,

   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // configuration
   logic [DIM_BITS-1:0] width_raw_ff, height_raw_ff;
   logic [DIM_BITS-1:0] width_ff, height_ff;
   pixel_type           dark_limit_ff, bright_limit_ff;
   logic                csr_wr;
   csr_index_type       csr_idx;
   logic [DIM_BITS-1:0] wdata_dim;
   logic [DIM_BITS-1:0] width_clamped, height_clamped;
   logic                restart;

   // position counters and totals
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [COUNT_BITS-1:0] dark_total_ff, bright_total_ff, normal_total_ff;
   logic [COUNT_BITS-1:0] dark_total_in, bright_total_in, normal_total_in;

   // stage 0 position decode
   logic [DIM_BITS-1:0] h_plus, h_minus, w_minus;
   logic [ROW_BITS-1:0] cr_wide;
   logic                col_zero, lower_ok, upper_ok, line_end;
   pos_meta_type        pos;
   pixel_type           pix_in;

   // pipeline control
   logic req_take, out_free;
   logic s1_go, s1_free, s2_go, s3_go, s3_free, s2_free, s1_load_s2;
   logic s1_v_ff, s2_v_ff, s3_v_ff, rsp_valid_ff;

   // stage 1
   pixel_type           s1_pix_ff;
   logic [COL_BITS-1:0] s1_addr_ff;
   pos_meta_type        s1_pos_ff;
   logic                fwd_ff;
   line_pair_type       fwd_pair_ff;
   line_pair_type       rd_pair;
   lsr_req_type         lsr_req;
   pixel_type           s1_top, s1_mid;

   // window
   window_type taps_ff, taps_in;
   window_type box;
   logic [2:0] row_ok, col_ok;
   pixel_type  centre;
   class_type  cls;

   rsp_meta_type s2_meta_ff, s3_meta_ff, out_meta_ff;
   pixel_type    median;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_wr    = psel && penable && pwrite;
   assign csr_idx   = csr_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wdata_dim = pwdata[DIM_BITS-1:0];
   assign restart   = csr_wr && (csr_idx == CSR_FRAME_WIDTH || csr_idx == CSR_FRAME_HEIGHT);

   always_comb begin
      width_clamped  = wdata_dim;
      height_clamped = wdata_dim;
      if (wdata_dim == '0) begin
         width_clamped  = DIM_BITS'(1);
         height_clamped = DIM_BITS'(1);
      end else begin
         if (wdata_dim > DIM_BITS'(MAX_WIDTH)) begin
            width_clamped = DIM_BITS'(MAX_WIDTH);
         end
         if (wdata_dim > DIM_BITS'(MAX_HEIGHT)) begin
            height_clamped = DIM_BITS'(MAX_HEIGHT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_raw_ff    <= WIDTH_RESET;
         height_raw_ff   <= HEIGHT_RESET;
         width_ff        <= WIDTH_RESET;
         height_ff       <= HEIGHT_RESET;
         dark_limit_ff   <= DARK_RESET;
         bright_limit_ff <= BRIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_FRAME_WIDTH: begin
               width_raw_ff <= wdata_dim;
               width_ff     <= width_clamped;
            end
            CSR_FRAME_HEIGHT: begin
               height_raw_ff <= wdata_dim;
               height_ff     <= height_clamped;
            end
            CSR_DARK_LIMIT:   dark_limit_ff   <= pwdata[PIXEL_BITS-1:0];
            CSR_BRIGHT_LIMIT: bright_limit_ff <= pwdata[PIXEL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_FRAME_WIDTH:  prdata = CSR_DATA_BITS'(width_raw_ff);
         CSR_FRAME_HEIGHT: prdata = CSR_DATA_BITS'(height_raw_ff);
         CSR_DARK_LIMIT:   prdata = CSR_DATA_BITS'(dark_limit_ff);
         CSR_BRIGHT_LIMIT: prdata = CSR_DATA_BITS'(bright_limit_ff);
         default:          prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s3_go      = s3_v_ff && out_free;
   assign s3_free    = !s3_v_ff || out_free;
   assign s2_go      = s2_v_ff && s3_free;
   assign s2_free    = !s2_v_ff || s3_free;
   // items that give no result leave the pipeline after the window shift
   assign s1_go      = s1_v_ff && (!s1_pos_ff.produce || s2_free);
   assign s1_free    = !s1_v_ff || s1_go;
   assign s1_load_s2 = s1_go && s1_pos_ff.produce;
   assign req_ready  = s1_free;
   assign req_take   = req_valid && s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_v_ff <= 1'b1;
         end else if (s1_go) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_load_s2) begin
            s2_v_ff <= 1'b1;
         end else if (s2_go) begin
            s2_v_ff <= 1'b0;
         end
         if (s2_go) begin
            s3_v_ff <= 1'b1;
         end else if (s3_go) begin
            s3_v_ff <= 1'b0;
         end
         if (s3_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- stage 0: position decode ----------------
   always_comb begin
      h_plus   = height_ff + DIM_BITS'(1);
      h_minus  = height_ff - DIM_BITS'(1);
      w_minus  = width_ff - DIM_BITS'(1);
      col_zero = (col_ff == '0);
      lower_ok = (row_ff >= ROW_BITS'(2)) || (row_ff == ROW_BITS'(1) && !col_zero);
      upper_ok = (row_ff <= ROW_BITS'(height_ff)) || (col_zero && row_ff == ROW_BITS'(h_plus));
      line_end = (DIM_BITS'(col_ff) == w_minus);
      // column zero closes the previous row: the centre sits at its end
      cr_wide  = col_zero ? row_ff - ROW_BITS'(2) : row_ff - ROW_BITS'(1);

      pos.produce  = lower_ok && upper_ok;
      pos.done     = lower_ok && col_zero && row_ff == ROW_BITS'(h_plus);
      pos.cc       = col_zero ? w_minus[COL_BITS-1:0] : col_ff - COL_BITS'(1);
      pos.cr       = cr_wide[OUT_ROW_BITS-1:0];
      pos.top_ok   = (cr_wide != '0);
      pos.bot_ok   = (cr_wide < ROW_BITS'(h_minus));
      pos.left_ok  = col_zero ? (width_ff >= DIM_BITS'(2)) : (col_ff >= COL_BITS'(2));
      pos.right_ok = !col_zero;

      if (pos.done) begin
         col_in = '0;
         row_in = '0;
      end else if (line_end) begin
         col_in = '0;
         row_in = row_ff + ROW_BITS'(1);
      end else begin
         col_in = col_ff + COL_BITS'(1);
         row_in = row_ff;
      end
   end

   assign pix_in = req_is_pad ? '0 : req_pixel;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         fwd_ff <= 1'b0;
      end else if (restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_take) begin
         col_ff <= col_in;
         row_ff <= row_in;
         // same column written at this edge: the read sees the old entry
         fwd_ff <= s1_go && (s1_addr_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pix_ff   <= pix_in;
         s1_addr_ff  <= col_ff;
         s1_pos_ff   <= pos;
         fwd_pair_ff <= '{upper: s1_mid, lower: s1_pix_ff};
      end
   end

   // ---------------- stage 1: line store and window ----------------
   always_comb begin
      lsr_req.rd_en   = req_take;
      lsr_req.rd_addr = col_ff;
      lsr_req.wr_en   = s1_go;
      lsr_req.wr_addr = s1_addr_ff;
      lsr_req.wr_data = '{upper: s1_mid, lower: s1_pix_ff};
   end

   mf3_line_store u_line_store (
      .clock   (clock),
      .req     (lsr_req),
      .rd_data (rd_pair)
   );

   assign s1_top = fwd_ff ? fwd_pair_ff.upper : rd_pair.upper;
   assign s1_mid = fwd_ff ? fwd_pair_ff.lower : rd_pair.lower;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         taps_in[r*3]   = taps_ff[r*3+1];
         taps_in[r*3+1] = taps_ff[r*3+2];
      end
      taps_in[2] = s1_top;
      taps_in[5] = s1_mid;
      taps_in[8] = s1_pix_ff;

      row_ok = {s1_pos_ff.bot_ok, 1'b1, s1_pos_ff.top_ok};
      col_ok = {s1_pos_ff.right_ok, 1'b1, s1_pos_ff.left_ok};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            box[r*3+c] = (row_ok[r] && col_ok[c]) ? taps_in[r*3+c] : '0;
         end
      end

      centre          = taps_in[4];
      dark_total_in   = dark_total_ff;
      bright_total_in = bright_total_ff;
      normal_total_in = normal_total_ff;
      priority if (centre < dark_limit_ff) begin
         cls           = CLASS_DARK;
         dark_total_in = dark_total_ff + COUNT_BITS'(1);
      end else if (centre > bright_limit_ff) begin
         cls             = CLASS_BRIGHT;
         bright_total_in = bright_total_ff + COUNT_BITS'(1);
      end else begin
         cls             = CLASS_NORMAL;
         normal_total_in = normal_total_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= '0;
      end else if (s1_go) begin
         taps_ff <= taps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         dark_total_ff   <= '0;
         bright_total_ff <= '0;
         normal_total_ff <= '0;
      end else if (s1_load_s2) begin
         if (s1_pos_ff.done) begin
            dark_total_ff   <= '0;
            bright_total_ff <= '0;
            normal_total_ff <= '0;
         end else begin
            dark_total_ff   <= dark_total_in;
            bright_total_ff <= bright_total_in;
            normal_total_ff <= normal_total_in;
         end
      end
   end

   // ---------------- stages 2, 3 and output ----------------
   always_ff @(posedge clock) begin
      if (s1_load_s2) begin
         s2_meta_ff <= '{cls:    cls,
                         cc:     s1_pos_ff.cc,
                         cr:     s1_pos_ff.cr,
                         done:   s1_pos_ff.done,
                         dark:   dark_total_in,
                         bright: bright_total_in,
                         normal: normal_total_in};
      end
      if (s2_go) begin
         s3_meta_ff <= s2_meta_ff;
      end
      if (s3_go) begin
         out_meta_ff <= s3_meta_ff;
      end
   end

   mf3_median u_median (
      .clock   (clock),
      .ld_box  (s1_load_s2),
      .ld_rows (s2_go),
      .ld_med  (s3_go),
      .box_in  (box),
      .median  (median)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_median        = median;
   assign rsp_center_class  = out_meta_ff.cls;
   assign rsp_center_column = out_meta_ff.cc;
   assign rsp_center_row    = out_meta_ff.cr;
   assign rsp_frame_done    = out_meta_ff.done;
   assign rsp_dark_count    = out_meta_ff.dark;
   assign rsp_bright_count  = out_meta_ff.bright;
   assign rsp_normal_count  = out_meta_ff.normal;

endmodule

[rtl/mf3_checker.sv]
module mf3_checker
   import mf3_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [PIXEL_BITS-1:0]    rsp_median,
   input logic [1:0]               rsp_center_class,
   input logic [COL_BITS-1:0]      rsp_center_column,
   input logic [OUT_ROW_BITS-1:0]  rsp_center_row,
   input logic                     rsp_frame_done,
   input logic [COUNT_BITS-1:0]    rsp_dark_count,
   input logic [COUNT_BITS-1:0]    rsp_bright_count,
   input logic [COUNT_BITS-1:0]    rsp_normal_count
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median)
         && $stable(rsp_center_column) && $stable(rsp_center_row))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // the centre pixel is already counted in its own class total
   a_class_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_center_class == CLASS_DARK && rsp_dark_count != '0)
         || (rsp_center_class == CLASS_BRIGHT && rsp_bright_count != '0)
         || (rsp_center_class == CLASS_NORMAL && rsp_normal_count != '0))
      else $error("centre class not reflected in totals");

   // last pixel of a frame: totals cover the whole frame
   a_frame_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |->
         (32'(rsp_dark_count) + 32'(rsp_bright_count) + 32'(rsp_normal_count))
            == ((32'(rsp_center_row) + 32'd1) * (32'(rsp_center_column) + 32'd1)))
      else $error("frame totals do not match frame size");

endmodule

bind median_filter_3x3_with_pixel_classes_top mf3_checker u_mf3_checker (.*);
